// ===== sv/etmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etmc_pkg;

   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned COST_W   = 18;
   localparam int unsigned SUM_W    = COST_W + 1;
   localparam int unsigned VTX_W    = 2;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SOLVE = 1'b1;

   // control for the shared add / compare unit, issued with the weight read
   typedef struct packed {
      logic clear;
      logic vld;
      logic first;
      logic last;
   } acc_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } perm_cmd_type;

endpackage

`default_nettype wire

// ===== sv/etmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface etmc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [etmc_pkg::VTX_W-1:0]    row;
   logic [etmc_pkg::VTX_W-1:0]    col;
   logic [etmc_pkg::WEIGHT_W-1:0] weight;

   modport source (output valid, output action, output row, output col, output weight,
                   input ready);
   modport sink   (input valid, input action, input row, input col, input weight,
                   output ready);
endinterface

interface etmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [etmc_pkg::COST_W-1:0] min_cost;

   modport source (output valid, output min_cost, input ready);
   modport sink   (input valid, input min_cost, output ready);
endinterface

`default_nettype wire

// ===== sv/etmc_wmem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module etmc_wmem #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire [etmc_pkg::WEIGHT_W-1:0]     wr_data,
   input  wire [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [etmc_pkg::WEIGHT_W-1:0]    rd_data
);

   logic [etmc_pkg::WEIGHT_W-1:0] weight_mem_ff [DEPTH];
   logic [etmc_pkg::WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= weight_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/etmc_perm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Swap-based permutation walk over the non-start vertices: one swap per step.
module etmc_perm #(
   parameter int unsigned NUM_VERTICES = 4
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  etmc_pkg::perm_cmd_type                        cmd,
   input  wire [$clog2(NUM_VERTICES)-1:0]                start_vtx,
   output logic [NUM_VERTICES-2:0][$clog2(NUM_VERTICES)-1:0] order,
   output logic                                          has_next
);

   localparam int unsigned VW = $clog2(NUM_VERTICES);
   localparam int unsigned M  = NUM_VERTICES - 1;
   localparam int unsigned CW = $clog2(M);

   logic [M-1:0][VW-1:0] order_ff, order_in, order_ld, order_sw;
   logic [M-1:1][CW-1:0] cnt_ff, cnt_in, cnt_step;
   logic [CW-1:0]        pick;
   logic [CW-1:0]        sel_cnt;
   logic [CW-1:0]        sw_a;
   logic [VW-1:0]        val_a, val_b;

   always_comb begin
      has_next = 1'b0;
      pick     = '0;
      // lowest level whose counter has not run out
      for (int i = M - 1; i >= 1; i--) begin
         if (cnt_ff[i] < CW'(i)) begin
            has_next = 1'b1;
            pick     = CW'(i);
         end
      end

      sel_cnt = '0;
      for (int i = 1; i < M; i++) begin
         if (CW'(i) == pick) begin
            sel_cnt = cnt_ff[i];
         end
      end
      // even level swaps with lane zero, odd level with the lane its counter names
      sw_a = pick[0] ? sel_cnt : '0;

      val_a = order_ff[0];
      val_b = order_ff[0];
      for (int j = 0; j < M; j++) begin
         if (CW'(j) == sw_a) begin
            val_a = order_ff[j];
         end
         if (CW'(j) == pick) begin
            val_b = order_ff[j];
         end
      end

      for (int j = 0; j < M; j++) begin
         if (CW'(j) == sw_a) begin
            order_sw[j] = val_b;
         end else if (CW'(j) == pick) begin
            order_sw[j] = val_a;
         end else begin
            order_sw[j] = order_ff[j];
         end
         order_ld[j] = (VW'(j) < start_vtx) ? VW'(j) : VW'(j + 1);
      end

      for (int i = 1; i < M; i++) begin
         if (CW'(i) < pick) begin
            cnt_step[i] = '0;
         end else if (CW'(i) == pick) begin
            cnt_step[i] = cnt_ff[i] + 1'b1;
         end else begin
            cnt_step[i] = cnt_ff[i];
         end
      end

      order_in = order_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         order_in = order_ld;
         cnt_in   = '0;
      end else if (cmd.step && has_next) begin
         order_in = order_sw;
         cnt_in   = cnt_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < M; j++) begin
            order_ff[j] <= VW'(j + 1);
         end
         cnt_ff <= '0;
      end else begin
         order_ff <= order_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign order = order_ff;

   a_step_has_next: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> has_next)
      else $error("permutation step past the last permutation");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cnt_ff == '0) && has_next)
      else $error("permutation counters not cleared by load");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("permutation load and step together");

endmodule

`default_nettype wire

// ===== sv/etmc_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared saturating adder and min compare; control is aligned to read data here.
module etmc_accum (
   input  wire                              clock,
   input  wire                              reset,
   input  etmc_pkg::acc_ctl_type            ctl,
   input  wire [etmc_pkg::WEIGHT_W-1:0]     rd_data,
   output logic [etmc_pkg::COST_W-1:0]      best
);

   etmc_pkg::acc_ctl_type          ctl_ff;
   logic [etmc_pkg::COST_W-1:0]    sum_ff, sum_in;
   logic [etmc_pkg::COST_W-1:0]    best_ff, best_in;
   logic [etmc_pkg::COST_W-1:0]    base;
   logic [etmc_pkg::SUM_W-1:0]     sum_ext;
   logic [etmc_pkg::COST_W-1:0]    sat;

   always_comb begin
      base    = ctl_ff.first ? '0 : sum_ff;
      sum_ext = {1'b0, base} + etmc_pkg::SUM_W'(rd_data);
      sat     = sum_ext[etmc_pkg::COST_W] ? etmc_pkg::COST_MAX
                                          : sum_ext[etmc_pkg::COST_W-1:0];
      sum_in  = ctl_ff.vld ? sat : sum_ff;

      best_in = best_ff;
      if (ctl.clear) begin
         best_in = etmc_pkg::COST_MAX;
      end else if (ctl_ff.vld && ctl_ff.last && (sat < best_ff)) begin
         best_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         sum_ff  <= '0;
         best_ff <= etmc_pkg::COST_MAX;
      end else begin
         ctl_ff  <= ctl;
         sum_ff  <= sum_in;
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

   a_best_monotone: assert property (@(posedge clock) disable iff (reset)
      !ctl.clear |=> best_ff <= $past(best_ff))
      else $error("best cost rose within a solve");

   a_clear_best: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> best_ff == etmc_pkg::COST_MAX)
      else $error("best cost not reset at solve start");

   a_tour_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.vld && ctl_ff.last && !ctl.clear) |=> best_ff <= sum_ff)
      else $error("finished tour below kept minimum");

endmodule

`default_nettype wire

// ===== sv/exhaustive_tour_min_cost.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                          Accepted when
// req_ch    in   action, row, col, weight         valid && ready
// rsp_ch    out  min_cost                         valid && ready
// csr_*     in   csr_wdata (start vertex)         csr_we at clock edge
//
// A solve folds NUM_VERTICES * (NUM_VERTICES-1)! edges through the single adder/compare
// unit, one per cycle (24 at four vertices), then folds the last edge in DRAIN and
// loads the result in FINISH. Permutations advance by one swap per tour.
// req_ch is not ready during a solve; a solve whose previous result still waits holds.
// Reset is synchronous; the weight matrix is not cleared and must be written first.
module exhaustive_tour_min_cost #(
   parameter int unsigned NUM_VERTICES = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   etmc_req_if.sink                     req_ch,
   etmc_rsp_if.source                   rsp_ch,
   input  wire                          csr_we,
   input  wire [etmc_pkg::VTX_W-1:0]    csr_wdata
);

   localparam int unsigned VW    = $clog2(NUM_VERTICES);
   localparam int unsigned SW    = VW + 1;
   localparam int unsigned M     = NUM_VERTICES - 1;
   localparam int unsigned DEPTH = NUM_VERTICES * NUM_VERTICES;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam logic [VW-1:0] EDGE_LAST = VW'(NUM_VERTICES - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [VW-1:0]                   edge_ff, edge_in;
   logic [VW-1:0]                   start_ff, start_in;
   logic [etmc_pkg::VTX_W-1:0]      csr_start_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [etmc_pkg::COST_W-1:0]     rsp_cost_ff, rsp_cost_in;

   logic                            req_acc;
   logic [SW-1:0]                   start_ext, start_wrap;
   logic [VW-1:0]                   eff_start;
   logic                            row_ok, col_ok;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr, rd_addr;
   logic [VW-1:0]                   from_vtx, to_vtx;
   logic [M-1:0][VW-1:0]            order;
   logic                            has_next;
   etmc_pkg::perm_cmd_type          perm_cmd;
   etmc_pkg::acc_ctl_type           acc_ctl;
   logic [etmc_pkg::WEIGHT_W-1:0]   rd_data;
   logic [etmc_pkg::COST_W-1:0]     best;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_start_ff <= '0;
      end else if (csr_we) begin
         csr_start_ff <= csr_wdata;
      end
   end

   // start vertex taken modulo the vertex count; it is below twice the count
   assign start_ext  = SW'(csr_start_ff);
   assign start_wrap = (start_ext >= SW'(NUM_VERTICES)) ? start_ext - SW'(NUM_VERTICES)
                                                        : start_ext;
   assign eff_start  = start_wrap[VW-1:0];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign row_ok  = SW'(req_ch.row) < SW'(NUM_VERTICES);
   assign col_ok  = SW'(req_ch.col) < SW'(NUM_VERTICES);
   assign wr_en   = req_acc && (req_ch.action == etmc_pkg::ACT_WRITE) && row_ok && col_ok;
   assign wr_addr = AW'(int'(req_ch.row) * NUM_VERTICES + int'(req_ch.col));

   // edge k of a tour runs from lane k-1 (or start) to lane k (or start)
   always_comb begin
      from_vtx = start_ff;
      to_vtx   = start_ff;
      for (int j = 0; j < M; j++) begin
         if (edge_ff == VW'(j + 1)) begin
            from_vtx = order[j];
         end
         if (edge_ff == VW'(j)) begin
            to_vtx = order[j];
         end
      end
   end

   assign rd_addr = AW'(int'(from_vtx) * NUM_VERTICES + int'(to_vtx));

   always_comb begin
      state_in      = state_ff;
      edge_in       = edge_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_cost_in   = rsp_cost_ff;
      perm_cmd      = '0;
      acc_ctl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.action == etmc_pkg::ACT_SOLVE)) begin
               state_in      = ST_RUN;
               start_in      = eff_start;
               edge_in       = '0;
               perm_cmd.load = 1'b1;
               acc_ctl.clear = 1'b1;
            end
         end
         ST_RUN: begin
            acc_ctl.vld   = 1'b1;
            acc_ctl.first = (edge_ff == '0);
            acc_ctl.last  = (edge_ff == EDGE_LAST);
            if (edge_ff == EDGE_LAST) begin
               edge_in = '0;
               if (has_next) begin
                  perm_cmd.step = 1'b1;
               end else begin
                  state_in = ST_DRAIN;
               end
            end else begin
               edge_in = edge_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last edge is being folded in
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait here while the previous item still sits on rsp_ch
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_cost_in  = best;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_ff      <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_ff      <= edge_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.min_cost = rsp_cost_ff;

   etmc_wmem #(
      .DEPTH (DEPTH)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.weight),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   etmc_perm #(
      .NUM_VERTICES (NUM_VERTICES)
   ) u_perm (
      .clock     (clock),
      .reset     (reset),
      .cmd       (perm_cmd),
      .start_vtx (eff_start),
      .order     (order),
      .has_next  (has_next)
   );

   etmc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .rd_data (rd_data),
      .best    (best)
   );

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("item raised outside solve completion");

   a_run_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && edge_ff == EDGE_LAST && !has_next) |=> state_ff == ST_DRAIN)
      else $error("solve did not end after last permutation");

   a_edge_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> edge_ff <= EDGE_LAST)
      else $error("edge counter out of range");

endmodule

`default_nettype wire

// ===== tb/exhaustive_tour_min_cost_tb.sv =====
`timescale 1ns / 1ps

module exhaustive_tour_min_cost_tb;

   localparam int NV = 4;
   localparam int VW = etmc_pkg::VTX_W;
   localparam int WW = etmc_pkg::WEIGHT_W;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 112;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                          action;
      logic [etmc_pkg::VTX_W-1:0]    row;
      logic [etmc_pkg::VTX_W-1:0]    col;
      logic [etmc_pkg::WEIGHT_W-1:0] weight;
      logic                          has_cost;
      logic [etmc_pkg::COST_W-1:0]   cost;
   } tour_cmd_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [etmc_pkg::VTX_W-1:0] csr_wdata;

   etmc_req_if req_if ();
   etmc_rsp_if rsp_if ();

   exhaustive_tour_min_cost #(.NUM_VERTICES(NV)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow state of the solver
   logic [etmc_pkg::WEIGHT_W-1:0] dist_mtx [NV][NV];
   logic [etmc_pkg::VTX_W-1:0]    tour_start;
   logic [etmc_pkg::COST_W-1:0]   pending_costs [$];

   int unsigned error_cnt;
   int unsigned cycle_cnt = 0;
   bit          no_idle;

   // all-FFFF matrix gives 4 * 65535 on every tour; the 0-1-2-3-0 cycle at zero gives 0
   tour_cmd_type directed_tbl [22] = '{
      '{etmc_pkg::ACT_WRITE, 2'd0, 2'd1, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd0, 2'd2, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd0, 2'd3, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd1, 2'd0, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd1, 2'd2, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd1, 2'd3, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd2, 2'd0, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd2, 2'd1, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd2, 2'd3, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd3, 2'd0, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd3, 2'd1, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd3, 2'd2, 16'hFFFF, 1'b0, 18'd0},
      '{etmc_pkg::ACT_SOLVE, 2'd0, 2'd0, 16'h0000, 1'b1, 18'd262140},
      '{etmc_pkg::ACT_WRITE, 2'd2, 2'd2, 16'h5A5A, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd0, 2'd1, 16'h0000, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd1, 2'd2, 16'h0000, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd2, 2'd3, 16'h0000, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd3, 2'd0, 16'h0000, 1'b0, 18'd0},
      '{etmc_pkg::ACT_SOLVE, 2'd3, 2'd3, 16'hFFFF, 1'b1, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd1, 2'd2, 16'h8001, 1'b0, 18'd0},
      '{etmc_pkg::ACT_WRITE, 2'd0, 2'd2, 16'h0007, 1'b0, 18'd0},
      '{etmc_pkg::ACT_SOLVE, 2'd1, 2'd2, 16'h1234, 1'b0, 18'd0}
   };

   function automatic int unsigned add_leg(int unsigned sum,
                                           logic [etmc_pkg::WEIGHT_W-1:0] w);
      int unsigned t;
      t = sum + w;
      return (t > etmc_pkg::COST_MAX) ? etmc_pkg::COST_MAX : t;
   endfunction

   // every order of the three non-start vertices; the minimum does not depend on visit order
   function automatic logic [etmc_pkg::COST_W-1:0] tour_min_cost();
      int unsigned s;
      int unsigned best;
      int unsigned sum;
      s = tour_start % NV;
      best = etmc_pkg::COST_MAX;
      for (int a = 0; a < NV; a++)
         for (int b = 0; b < NV; b++)
            for (int c = 0; c < NV; c++) begin
               if (a == s || b == s || c == s || a == b || a == c || b == c)
                  continue;
               sum = add_leg(0, dist_mtx[s][a]);
               sum = add_leg(sum, dist_mtx[a][b]);
               sum = add_leg(sum, dist_mtx[b][c]);
               sum = add_leg(sum, dist_mtx[c][s]);
               if (sum < best)
                  best = sum;
            end
      return best[etmc_pkg::COST_W-1:0];
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic tour_cmd_type random_cmd();
      tour_cmd_type cmd;
      cmd = '0;
      cmd.action = ($urandom_range(0, 3) == 0) ? etmc_pkg::ACT_SOLVE : etmc_pkg::ACT_WRITE;
      cmd.row = VW'($urandom_range(0, NV - 1));
      cmd.col = VW'($urandom_range(0, NV - 1));
      case ($urandom_range(0, 7))
         0: cmd.weight = 16'h0000;
         1: cmd.weight = 16'hFFFF;
         2, 3: cmd.weight = WW'($urandom_range(0, 31));
         default: cmd.weight = WW'($urandom());
      endcase
      return cmd;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_cnt++;
   endtask

   task automatic send_cmd(input tour_cmd_type cmd);
      int unsigned gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= cmd.action;
      req_if.row    <= cmd.row;
      req_if.col    <= cmd.col;
      req_if.weight <= cmd.weight;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      if (cmd.action == etmc_pkg::ACT_WRITE)
         dist_mtx[cmd.row][cmd.col] = cmd.weight;
      else
         pending_costs.insert(pending_costs.size(),
                              cmd.has_cost ? cmd.cost : tour_min_cost());
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_costs.size() != 0)
         @(posedge clock);
      // a trailing write may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_start_vertex(input logic [etmc_pkg::VTX_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      tour_start = v;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("exhaustive_tour_min_cost_tb: FAIL");
         $finish;
      end
   end

   // result side: random backpressure, compare against oldest expected cost
   initial begin
      int unsigned hold;
      bit rdy;
      logic [etmc_pkg::COST_W-1:0] want;
      hold = 0;
      rdy = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_costs.size() == 0) begin
               report_mismatch($sformatf("min_cost %0d with no solve pending", rsp_if.min_cost));
            end else begin
               want = pending_costs.pop_front();
               if (rsp_if.min_cost !== want)
                  report_mismatch($sformatf("min_cost %0d, expected %0d", rsp_if.min_cost, want));
            end
         end
         if (hold == 0) begin
            rdy = no_idle || ($urandom_range(0, 2) != 0);
            hold = rdy ? $urandom_range(1, 6) : 1 + gap_len();
         end
         hold--;
         rsp_if.ready <= rdy;
      end
   end

   initial begin
      logic [etmc_pkg::VTX_W-1:0] sv_val;
      error_cnt = 0;
      no_idle = 1'b0;
      tour_start = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.action = etmc_pkg::ACT_WRITE;
      req_if.row = '0;
      req_if.col = '0;
      req_if.weight = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tbl[i])
         send_cmd(directed_tbl[i]);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: sv_val = 2'd3;
            1: sv_val = 2'd0;
            2: sv_val = 2'd1;
            3: sv_val = 2'd2;
            default: sv_val = VW'($urandom_range(0, NV - 1));
         endcase
         set_start_vertex(sv_val);
         no_idle = (ph % 3 == 1);
         repeat (PHASE_ITEMS)
            send_cmd(random_cmd());
         no_idle = 1'b0;
         drain();
      end

      if (error_cnt == 0)
         $display("exhaustive_tour_min_cost_tb: PASS");
      else
         $display("exhaustive_tour_min_cost_tb: FAIL");
      $finish;
   end

endmodule
